@@ src/b64u_pkg.sv @@
`timescale 1ns / 1ps
package b64u_pkg;

  localparam int LENGTH_BITS = 16;
  localparam int CAP_W = 16;
  localparam int LEN_OUT_W = 16;
  // wide enough for the count plus a group and for the capacity
  localparam int CMP_W = ((LENGTH_BITS > CAP_W) ? LENGTH_BITS : CAP_W) + 1;
  localparam logic [CAP_W-1:0] CAP_RESET = 16'hffff;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_CHAR = 3'd1,
    ST_LENGTH   = 3'd2,
    ST_CAPACITY = 3'd3,
    ST_PAD_BITS = 3'd4
  } status_t;

  // results of one character, at most three bytes then one status word
  typedef struct packed {
    logic [1:0]           nbytes;
    logic [2:0][7:0]      data;
    logic                 has_status;
    status_t              status;
    logic [LEN_OUT_W-1:0] length;
  } bundle_t;

  // bit 6 flags a character inside the alphabet
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c >= "A" && c <= "Z") begin
      r = {1'b1, 6'(c - "A")};
    end else if (c >= "a" && c <= "z") begin
      r = {1'b1, 6'(c - "a" + 8'd26)};
    end else if (c >= "0" && c <= "9") begin
      r = {1'b1, 6'(c - "0" + 8'd52)};
    end else if (c == "-") begin
      r = {1'b1, 6'd62};
    end else if (c == "_") begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

@@ src/b64u_if.sv @@
`timescale 1ns / 1ps
interface b64u_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_of_string;
  modport source (output valid, output in_char, output end_of_string, input ready);
  modport sink (input valid, input in_char, input end_of_string, output ready);
endinterface

interface b64u_out_if;
  logic                           valid;
  logic                           ready;
  logic [7:0]                     out_byte;
  logic                           is_status;
  logic [2:0]                     status;
  logic [b64u_pkg::LEN_OUT_W-1:0] decoded_length;
  logic                           last;
  modport source (output valid, output out_byte, output is_status, output status,
                  output decoded_length, output last, input ready);
  modport sink (input valid, input out_byte, input is_status, input status,
                input decoded_length, input last, output ready);
endinterface

interface b64u_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [b64u_pkg::CAP_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/base64url_strict_decoder_unit.sv @@
`timescale 1ns / 1ps
// Strict unpadded base64url decoder. One character is taken per clock while
// the buffer has room; the word flagged end_of_string closes the string and
// brings one status word (ok, bad character, length 1 mod 4, over capacity,
// nonzero pad bits) after any final bytes, with last set on the final word a
// character causes. A character yields zero to four output words, which
// leave one per clock while ready is high from a two-slot output buffer, so
// the sustained rate is one character per cycle unless the serializer is the
// bottleneck: a group of four characters yields three words. Bytes already
// delivered for a string whose status is not ok must be dropped by the user.
// The capacity register may be written at any time the block is idle.
module base64url_strict_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  b64u_in_if.sink     in_if,
  b64u_cfg_if.sink    cfg_if,
  b64u_out_if.source  out_if
);

  logic              push;
  logic              q_ready;
  b64u_pkg::bundle_t bundle;

  b64u_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .cfg_if  (cfg_if),
    .q_ready (q_ready),
    .push    (push),
    .bundle  (bundle)
  );

  b64u_out u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .bundle  (bundle),
    .q_ready (q_ready),
    .out_if  (out_if)
  );

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.is_status |-> out_if.last)
    else $error("status word without last");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> out_if.valid)
    else $error("input stalled with no pending output");

  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.is_status |->
      out_if.status == b64u_pkg::ST_OK && out_if.decoded_length == '0)
    else $error("data word carries status fields");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.out_byte)
      && $stable(out_if.is_status))
    else $error("stalled output word changed");

endmodule

@@ src/b64u_core.sv @@
`timescale 1ns / 1ps
module b64u_core (
  input  logic              clk,
  input  logic              rst_n,
  b64u_in_if.sink           in_if,
  b64u_cfg_if.sink          cfg_if,
  input  logic              q_ready,
  output logic              push,
  output b64u_pkg::bundle_t bundle
);

  logic [b64u_pkg::CAP_W-1:0]       cap_r;
  logic [1:0]                       pos_r, pos_nxt;
  logic [17:0]                      hold_r, hold_nxt;
  logic [b64u_pkg::LENGTH_BITS-1:0] wc_r, wc_nxt;
  b64u_pkg::status_t                err_r, err_nxt;

  logic                         accept;
  logic [6:0]                   sx;
  logic [23:0]                  acc;
  logic [1:0]                   nb;
  logic [b64u_pkg::CMP_W-1:0]   sum;
  logic                         over;
  logic                         pad_bad;
  logic [2:0][7:0]              bytes;
  b64u_pkg::status_t            err_a;

  assign accept       = in_if.valid && q_ready;
  assign in_if.ready  = q_ready;
  assign cfg_if.ready = 1'b1;

  always_comb begin
    sx      = b64u_pkg::sextet_of(in_if.in_char);
    pos_nxt = pos_r + 2'd1;
    err_a   = err_r;
    if (err_r == b64u_pkg::ST_OK && !sx[6]) begin
      err_a = b64u_pkg::ST_BAD_CHAR;
    end
    acc     = {hold_r, sx[5:0]};
    nb      = 2'd0;
    bytes   = '0;
    pad_bad = 1'b0;
    // only one group can close per character
    if (err_a == b64u_pkg::ST_OK) begin
      if (pos_r == 2'd3) begin
        nb    = 2'd3;
        bytes = {acc[7:0], acc[15:8], acc[23:16]};
      end else if (in_if.end_of_string && pos_r == 2'd2) begin
        nb      = 2'd2;
        bytes   = {8'd0, acc[9:2], acc[17:10]};
        pad_bad = acc[1:0] != 2'b00;
      end else if (in_if.end_of_string && pos_r == 2'd1) begin
        nb      = 2'd1;
        bytes   = {16'd0, acc[11:4]};
        pad_bad = acc[3:0] != 4'd0;
      end
    end
    sum  = b64u_pkg::CMP_W'(wc_r) + b64u_pkg::CMP_W'(nb);
    over = sum > b64u_pkg::CMP_W'(cap_r);

    err_nxt  = err_a;
    wc_nxt   = wc_r;
    hold_nxt = hold_r;
    if (err_a == b64u_pkg::ST_OK) begin
      hold_nxt = (pos_r == 2'd3) ? 18'd0 : acc[17:0];
    end
    if (nb != 2'd0) begin
      if (over) begin
        err_nxt = b64u_pkg::ST_CAPACITY;
      end else begin
        wc_nxt = sum[b64u_pkg::LENGTH_BITS-1:0];
        if (pad_bad) begin
          err_nxt = b64u_pkg::ST_PAD_BITS;
        end
      end
    end

    bundle.nbytes     = over ? 2'd0 : nb;
    bundle.data       = bytes;
    bundle.has_status = in_if.end_of_string;
    bundle.status     = (pos_nxt == 2'd1) ? b64u_pkg::ST_LENGTH : err_nxt;
    bundle.length     = b64u_pkg::LEN_OUT_W'(b64u_pkg::CMP_W'(wc_nxt));
    push = accept && (bundle.nbytes != 2'd0 || in_if.end_of_string);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= b64u_pkg::CAP_RESET;
      pos_r  <= 2'd0;
      hold_r <= 18'd0;
      wc_r   <= '0;
      err_r  <= b64u_pkg::ST_OK;
    end else begin
      if (cfg_if.valid) begin
        cap_r <= cfg_if.data;
      end
      if (accept) begin
        if (in_if.end_of_string) begin
          pos_r  <= 2'd0;
          hold_r <= 18'd0;
          wc_r   <= '0;
          err_r  <= b64u_pkg::ST_OK;
        end else begin
          pos_r  <= pos_nxt;
          hold_r <= hold_nxt;
          wc_r   <= wc_nxt;
          err_r  <= err_nxt;
        end
      end
    end
  end

endmodule

@@ src/b64u_out.sv @@
`timescale 1ns / 1ps
module b64u_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  b64u_pkg::bundle_t bundle,
  output logic              q_ready,
  b64u_out_if.source        out_if
);

  b64u_pkg::bundle_t head_r, spare_r;
  logic              head_v_r, spare_v_r;
  logic [1:0]        idx_r;

  logic       is_byte;
  logic [2:0] total;
  logic       last_word;
  logic       take;
  logic       done;

  assign q_ready = !spare_v_r;

  always_comb begin
    total     = {1'b0, head_r.nbytes} + {2'b00, head_r.has_status};
    is_byte   = idx_r < head_r.nbytes;
    last_word = ({1'b0, idx_r} + 3'd1) == total;
    take      = head_v_r && out_if.ready;
    done      = take && last_word;

    out_if.valid          = head_v_r;
    out_if.last           = last_word;
    out_if.is_status      = !is_byte;
    out_if.status         = is_byte ? b64u_pkg::ST_OK : head_r.status;
    out_if.decoded_length = is_byte ? '0 : head_r.length;
    case (idx_r)
      2'd0:    out_if.out_byte = is_byte ? head_r.data[0] : 8'd0;
      2'd1:    out_if.out_byte = is_byte ? head_r.data[1] : 8'd0;
      2'd2:    out_if.out_byte = is_byte ? head_r.data[2] : 8'd0;
      default: out_if.out_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r  <= 1'b0;
      spare_v_r <= 1'b0;
      idx_r     <= 2'd0;
    end else begin
      if (done) begin
        idx_r <= 2'd0;
        if (spare_v_r) begin
          head_r    <= spare_r;
          spare_v_r <= 1'b0;
        end else if (push) begin
          head_r <= bundle;
        end else begin
          head_v_r <= 1'b0;
        end
      end else if (head_v_r) begin
        if (take) begin
          idx_r <= idx_r + 2'd1;
        end
        // second slot keeps the input moving while the output stalls
        if (push) begin
          spare_r   <= bundle;
          spare_v_r <= 1'b1;
        end
      end else if (push) begin
        head_r   <= bundle;
        head_v_r <= 1'b1;
        idx_r    <= 2'd0;
      end
    end
  end

endmodule
